/* src/tws_pkg.sv */
package tws_pkg;

  localparam int CACHE_LINES = 16;
  localparam int WAYS        = 2;
  localparam int SETS        = CACHE_LINES / WAYS;
  localparam int MEM_WORDS   = 128;
  localparam int REG_COUNT   = 8;

  localparam int SET_W  = $clog2(SETS);
  localparam int ADDR_W = $clog2(MEM_WORDS);
  localparam int TAG_W  = (ADDR_W > SET_W) ? ADDR_W - SET_W : 1;
  localparam int REG_W  = $clog2(REG_COUNT);

  localparam logic [5:0]  OP_LOAD  = 6'd35;
  localparam logic [5:0]  OP_STORE = 6'd43;
  localparam logic [4:0]  REG_BASE = 5'd16;
  localparam logic [31:0] MEM_BIAS = 32'd5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_OP   = 2'd1,
    ST_BAD_REG  = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_t;

  typedef logic [31:0]       word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SET_W-1:0]  set_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [REG_W-1:0]  reg_t;

  // Main memory access request: one read port and one write port.
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
  } mem_req_t;

endpackage

/* src/tws_req_if.sv */
interface tws_req_if;
  import tws_pkg::*;

  logic  valid;
  logic  ready;
  word_t instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

/* src/tws_rsp_if.sv */
interface tws_rsp_if;
  import tws_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic               hit;
  logic               wrote_back;
  logic signed [31:0] load_value;

  modport source (output valid, output status, output hit, output wrote_back,
                  output load_value, input ready);
  modport sink (input valid, input status, input hit, input wrote_back,
                input load_value, output ready);
endinterface

/* src/tws_mem.sv */
module tws_mem (
  input  logic              clk,
  input  logic              rst,
  input  tws_pkg::mem_req_t req,
  output tws_pkg::word_t    rd_word
);
  import tws_pkg::*;

  word_t mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] written;

  word_t mem_q;
  word_t fwd_data;
  logic  fwd;
  logic  rd_written;
  addr_t rd_addr_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  // Words never written read as their preset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      fwd        <= 1'b0;
      rd_written <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        fwd        <= req.wr_en && (req.wr_addr == req.rd_addr);
        rd_written <= written[req.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_addr_q <= req.rd_addr;
      fwd_data  <= req.wr_data;
    end
  end

  assign rd_word = fwd        ? fwd_data :
                   rd_written ? mem_q    :
                   word_t'(rd_addr_q) + MEM_BIAS;

endmodule

/* src/two_way_cache_load_store.sv */
// A result passes through the decode stage register and then the result register
// before it is valid.
// Throughput: one instruction per cycle, loads and stores, hits and misses alike, while rsp.ready holds.
// The main memory has one read and one write port; a write that meets a read of
// the same word in the same cycle is forwarded to the read.
// Reset (synchronous, active high) clears line valid bits, LRU bits, the register
// file and the memory-written bits at once; no clearing pass is needed.
module two_way_cache_load_store (
  input logic      clk,
  input logic      rst,
  tws_req_if.sink  req,
  tws_rsp_if.source rsp
);
  import tws_pkg::*;

  // Decode stage holds the instruction; the memory word arrives alongside it.
  logic  s1_valid;
  word_t s1_instr;
  logic  s1_fire;
  logic  out_valid;

  // Cache arrays indexed by set: valid, tag and data per way, one LRU bit per set.
  logic  v0 [SETS];
  logic  v1 [SETS];
  tag_t  tag0 [SETS];
  tag_t  tag1 [SETS];
  word_t data0 [SETS];
  word_t data1 [SETS];
  logic  lru [SETS];
  word_t rf [REG_COUNT];

  mem_req_t mem_req;
  word_t    mem_word;

  logic [5:0]  op;
  logic [4:0]  rt;
  logic [13:0] word_addr;
  status_t     status;
  logic        ok;
  logic        is_load;
  reg_t        reg_idx;
  addr_t       addr;
  set_t        set_idx;
  tag_t        tag;
  logic        hit0;
  logic        hit1;
  logic        hit;
  logic        hit_way;
  logic        victim;
  logic        vict_valid;
  tag_t        vict_tag;
  word_t       vict_data;
  logic        use_way;
  word_t       value;
  logic        wb;

  // Advance the decode stage when the result register is free or draining.
  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_instr <= req.instruction;
    end
  end

  // Field decode and the checks, in priority order.
  always_comb begin
    op        = s1_instr[31:26];
    rt        = s1_instr[20:16];
    word_addr = s1_instr[15:2];
    reg_idx   = REG_W'(rt - REG_BASE);
    addr      = s1_instr[ADDR_W+1:2];
    set_idx   = addr[SET_W-1:0];
    tag       = TAG_W'(addr >> SET_W);
    is_load   = (op == OP_LOAD);
    if (op != OP_LOAD && op != OP_STORE) begin
      status = ST_BAD_OP;
    end else if (rt < REG_BASE || {1'b0, rt} >= 6'(REG_BASE) + 6'(REG_COUNT)) begin
      status = ST_BAD_REG;
    end else if ({1'b0, word_addr} >= 15'(MEM_WORDS)) begin
      status = ST_BAD_ADDR;
    end else begin
      status = ST_OK;
    end
    ok = (status == ST_OK);
  end

  // Tag compare; way 0 wins if both ways match.
  always_comb begin
    hit0       = v0[set_idx] && (tag0[set_idx] == tag);
    hit1       = v1[set_idx] && (tag1[set_idx] == tag);
    hit        = hit0 || hit1;
    hit_way    = !hit0;
    victim     = lru[set_idx];
    vict_valid = victim ? v1[set_idx] : v0[set_idx];
    vict_tag   = victim ? tag1[set_idx] : tag0[set_idx];
    vict_data  = victim ? data1[set_idx] : data0[set_idx];
    use_way    = hit ? hit_way : victim;
    value      = hit ? (hit_way ? data1[set_idx] : data0[set_idx]) : mem_word;
    wb         = is_load && !hit && vict_valid;
  end

  // Memory port: read for the incoming transaction, write for the committing one.
  // Writeback goes to the victim's address; a store miss writes straight through.
  always_comb begin
    mem_req.rd_en   = req.valid && req.ready;
    mem_req.rd_addr = req.instruction[ADDR_W+1:2];
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = addr;
    mem_req.wr_data = rf[reg_idx];
    if (s1_fire && ok) begin
      if (is_load) begin
        mem_req.wr_en   = wb;
        mem_req.wr_addr = ADDR_W'({vict_tag, set_idx});
        mem_req.wr_data = vict_data;
      end else begin
        mem_req.wr_en = !hit;
      end
    end
  end

  tws_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_word (mem_word)
  );

  // Control state of the cache: valid bits, LRU bits, register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SETS; i++) begin
        v0[i]  <= 1'b0;
        v1[i]  <= 1'b0;
        lru[i] <= 1'b0;
      end
      for (int i = 0; i < REG_COUNT; i++) begin
        rf[i] <= '0;
      end
    end else if (s1_fire && ok) begin
      if (is_load) begin
        rf[reg_idx]  <= value;
        lru[set_idx] <= !use_way;
        if (!hit) begin
          if (victim) begin
            v1[set_idx] <= 1'b1;
          end else begin
            v0[set_idx] <= 1'b1;
          end
        end
      end else if (hit) begin
        lru[set_idx] <= !hit_way;
      end
    end
  end

  // Line payload: fill on a load miss, update on a store hit.
  always_ff @(posedge clk) begin
    if (s1_fire && ok) begin
      if (is_load && !hit) begin
        if (victim) begin
          tag1[set_idx]  <= tag;
          data1[set_idx] <= mem_word;
        end else begin
          tag0[set_idx]  <= tag;
          data0[set_idx] <= mem_word;
        end
      end else if (!is_load && hit) begin
        if (hit_way) begin
          data1[set_idx] <= rf[reg_idx];
        end else begin
          data0[set_idx] <= rf[reg_idx];
        end
      end
    end
  end

  // Result register: hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp.status     <= status;
      rsp.hit        <= ok && hit;
      rsp.wrote_back <= ok && wb;
      rsp.load_value <= (ok && is_load) ? value : '0;
    end
  end

  assign rsp.valid = out_valid;

endmodule

/* src/tws_checker.sv */
module tws_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         rsp_status,
  input logic               rsp_hit,
  input logic               rsp_wrote_back,
  input logic signed [31:0] rsp_load_value
);
  import tws_pkg::*;

  // Nothing is pending right after reset.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_hit) &&
      $stable(rsp_wrote_back) && $stable(rsp_load_value))
    else $error("result changed while stalled");

  // A rejected instruction reports nothing else.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |->
      !rsp_hit && !rsp_wrote_back && rsp_load_value == 0)
    else $error("error result carries data");

  // Writeback only happens on a miss.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_wrote_back |-> !rsp_hit && rsp_status == ST_OK)
    else $error("writeback on a hit");

endmodule

bind two_way_cache_load_store tws_checker u_tws_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_hit        (rsp.hit),
  .rsp_wrote_back (rsp.wrote_back),
  .rsp_load_value (rsp.load_value)
);
